FILE: sv/ibrd_pkg.sv
package ibrd_pkg;

  // sizes of the local stores
  localparam int unsigned LINE_WORDS = 720;
  localparam int unsigned GPU_BYTES  = 4096;
  localparam int unsigned DSP_BYTES  = 8192;

  localparam int unsigned GPU_WORDS = GPU_BYTES / 4;
  localparam int unsigned DSP_WORDS = DSP_BYTES / 4;
  localparam int unsigned LINE_AW   = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;
  localparam int unsigned GPU_AW    = $clog2(GPU_WORDS);
  localparam int unsigned DSP_AW    = $clog2(DSP_WORDS);
  localparam int unsigned CLUT_AW   = 8;

  // line index taken from the address is always ten bits wide
  localparam logic [10:0] LINE_LIMIT = 11'(LINE_WORDS);

  // address map
  localparam logic [23:0] SPACE_START  = 24'h100000;
  localparam logic [23:0] SPACE_END    = 24'h120000;
  localparam logic [23:0] REG_END      = 24'h100400;
  localparam logic [23:0] CLUT_END     = 24'h100800;
  localparam logic [23:0] LINE_B_START = 24'h101000;
  localparam logic [23:0] LINE_W_START = 24'h101800;
  localparam logic [23:0] LINE_END     = 24'h102100;
  localparam logic [23:0] GPU_START    = 24'h103000;
  localparam logic [23:0] GPU_END      = 24'h110000;
  localparam logic [23:0] DSP_START    = 24'h11B000;
  localparam logic [23:0] DSP_END      = 24'h11D000;

  // register block offsets
  localparam logic [9:0] OFS_MEMCON1  = 10'h000;
  localparam logic [9:0] OFS_MEMCON2  = 10'h002;
  localparam logic [9:0] OFS_INT_CTRL = 10'h0E0;
  localparam logic [9:0] OFS_INT_AUX  = 10'h0E2;

  localparam logic [15:0] UNHANDLED_DATA = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_RAISE = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    RGN_NONE,
    RGN_REG,
    RGN_CLUT,
    RGN_LINE_A,
    RGN_LINE_B,
    RGN_LINE_W,
    RGN_GPU,
    RGN_DSP
  } region_e;

  // decoded access
  typedef struct packed {
    logic                 rd;
    logic                 wr;
    logic                 raise;
    region_e              rgn;
    logic                 reg_mc1;
    logic                 reg_int;
    logic                 handled;
    logic [15:0]          wdata;
    logic [CLUT_AW-1:0]   clut_idx;
    logic [LINE_AW-1:0]   line_idx;
    logic [GPU_AW-1:0]    gpu_idx;
    logic [DSP_AW-1:0]    dsp_idx;
    logic                 half_lo;
    logic                 lane_odd;
    logic                 byte_acc;
  } dec_t;

  // status after an access
  typedef struct packed {
    logic       irq;
    logic       rom_high;
    logic [3:0] wait_cycles;
  } stat_t;

  // cartridge wait cycles by memory control bits 4:3
  function automatic logic [3:0] wait_cycles_f(input logic [1:0] sel);
    logic [3:0] w;
    case (sel)
      2'd0:    w = 4'd10;
      2'd1:    w = 4'd8;
      2'd2:    w = 4'd6;
      default: w = 4'd5;
    endcase
    return w;
  endfunction

endpackage

FILE: sv/ibrd_ram.sv
module ibrd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/ibrd_decode.sv
module ibrd_decode
  import ibrd_pkg::*;
(
  input  logic [1:0]  command_i,
  input  logic [23:0] address_i,
  input  logic [15:0] write_data_i,
  input  logic        byte_access_i,
  output dec_t        dec_o
);

  logic [9:0]  ofs;
  logic [9:0]  line_full;
  logic        line_ok;
  logic        mc2_hit;
  logic        aux_hit;
  region_e     rgn;

  assign ofs       = {address_i[9:1], 1'b0};
  assign line_full = address_i[10:1];
  assign line_ok   = {1'b0, line_full} < LINE_LIMIT;
  assign mc2_hit   = (rgn == RGN_REG) && (ofs == OFS_MEMCON2);
  assign aux_hit   = (rgn == RGN_REG) && (ofs == OFS_INT_AUX);

  // region select
  always_comb begin
    rgn = RGN_NONE;
    if (address_i >= SPACE_START && address_i < SPACE_END) begin
      if (address_i < REG_END) begin
        rgn = RGN_REG;
      end else if (address_i < CLUT_END) begin
        rgn = RGN_CLUT;
      end else if (address_i < LINE_END) begin
        if (line_ok) begin
          if (address_i < LINE_B_START) begin
            rgn = RGN_LINE_A;
          end else if (address_i < LINE_W_START) begin
            rgn = RGN_LINE_B;
          end else begin
            rgn = RGN_LINE_W;
          end
        end
      end else if (address_i >= GPU_START && address_i < GPU_END) begin
        rgn = RGN_GPU;
      end else if (address_i >= DSP_START && address_i < DSP_END) begin
        rgn = RGN_DSP;
      end
    end
  end

  // command, data lanes and indexes
  always_comb begin
    dec_o          = '0;
    dec_o.rd       = (command_i == CMD_READ);
    dec_o.wr       = (command_i == CMD_WRITE);
    dec_o.raise    = (command_i == CMD_RAISE);
    dec_o.rgn      = rgn;
    dec_o.reg_mc1  = (rgn == RGN_REG) && (ofs == OFS_MEMCON1);
    dec_o.reg_int  = (rgn == RGN_REG) && (ofs == OFS_INT_CTRL);
    dec_o.wdata    = byte_access_i ? {write_data_i[7:0], write_data_i[7:0]} : write_data_i;
    dec_o.clut_idx = address_i[CLUT_AW:1];
    dec_o.line_idx = address_i[LINE_AW:1];
    dec_o.gpu_idx  = address_i[GPU_AW+1:2];
    dec_o.dsp_idx  = address_i[DSP_AW+1:2];
    dec_o.half_lo  = address_i[1];
    dec_o.lane_odd = address_i[0];
    dec_o.byte_acc = byte_access_i;

    // register block answers reads only at the interrupt control word
    if (dec_o.raise) begin
      dec_o.handled = 1'b1;
    end else if (dec_o.rd || dec_o.wr) begin
      if (rgn == RGN_REG) begin
        dec_o.handled = dec_o.reg_int ||
                        (dec_o.wr && (dec_o.reg_mc1 || mc2_hit || aux_hit));
      end else begin
        dec_o.handled = (rgn != RGN_NONE);
      end
    end
  end

endmodule

FILE: sv/ibrd_ctrl_regs.sv
module ibrd_ctrl_regs
  import ibrd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  dec_t       dec_i,
  input  logic [4:0] raise_mask_i,
  output logic [4:0] pending_o,
  output stat_t      stat_o
);

  logic [4:0] int_en_q, int_en_d;
  logic [4:0] int_pend_q, int_pend_d;
  logic       rom_high_q, rom_high_d;
  logic       seen_q, seen_d;
  logic [3:0] wait_q, wait_d;

  // memory control two has no visible effect, its writes are acknowledged only
  always_comb begin
    int_en_d   = int_en_q;
    int_pend_d = int_pend_q;
    rom_high_d = rom_high_q;
    seen_d     = seen_q;
    wait_d     = wait_q;
    if (accept_i) begin
      if (dec_i.wr && dec_i.reg_mc1) begin
        // wait cycles reload on first write or when the rom bit flips
        if ((dec_i.wdata[0] ^ rom_high_q) || !seen_q) begin
          seen_d = 1'b1;
          wait_d = wait_cycles_f(dec_i.wdata[4:3]);
        end
        rom_high_d = dec_i.wdata[0];
      end
      if (dec_i.wr && dec_i.reg_int) begin
        int_en_d   = dec_i.wdata[4:0];
        int_pend_d = int_pend_q & ~dec_i.wdata[12:8];
      end
      if (dec_i.raise) begin
        int_pend_d = int_pend_q | raise_mask_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_en_q   <= '0;
      int_pend_q <= '0;
      rom_high_q <= 1'b0;
      seen_q     <= 1'b0;
      wait_q     <= '0;
    end else begin
      int_en_q   <= int_en_d;
      int_pend_q <= int_pend_d;
      rom_high_q <= rom_high_d;
      seen_q     <= seen_d;
      wait_q     <= wait_d;
    end
  end

  // status as it stands after this access
  assign pending_o          = int_pend_q;
  assign stat_o.irq         = |(int_en_d & int_pend_d);
  assign stat_o.rom_high    = rom_high_d;
  assign stat_o.wait_cycles = wait_d;

endmodule

FILE: sv/internal_bus_register_decoder_unit.sv
// Internal bus decoder for the 0x100000-0x11FFFF space: colour table, three
// line stores, GPU and DSP local RAM (each held as high and low half-word
// RAMs), memory control and interrupt enable/pending registers. One access
// is taken per cycle while results are being taken. The transfer edge starts
// the registered read of the single-port RAMs and loads stage one. From stage
// one the access moves into the output register, which drives the outputs.
// A result that waits in the output register holds stage one, and with it
// the input. Every access touches each RAM at most once, so reads and writes
// never compete for a port. The RAMs power up undefined and need no clearing
// pass; locations never written read back unspecified data.
module internal_bus_register_decoder_unit
  import ibrd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [23:0] address_i,
  input  logic [15:0] write_data_i,
  input  logic        byte_access_i,
  input  logic [4:0]  raise_mask_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] read_data_o,
  output logic        handled_o,
  output logic        irq_o,
  output logic        rom_high_o,
  output logic [3:0]  rom_wait_cycles_o
);

  dec_t       dec;
  stat_t      stat_d;
  logic [4:0] pending;
  logic       accept;
  logic       adv;

  logic       s1_valid_q;
  region_e    s1_rgn_q;
  logic       s1_rd_q;
  logic       s1_handled_q;
  logic       s1_byte_q;
  logic       s1_lane_q;
  logic       s1_half_q;
  logic [4:0] s1_pend_q;
  stat_t      s1_stat_q;

  logic        out_valid_q;
  logic [15:0] out_data_q, out_data_d;
  logic        out_handled_q;
  stat_t       out_stat_q;

  logic [15:0] clut_rd, line_a_rd, line_b_rd, line_w_rd;
  logic [15:0] gpu_hi_rd, gpu_lo_rd, dsp_hi_rd, dsp_lo_rd;
  logic [15:0] word_val;
  logic        mem_op;

  ibrd_decode u_decode (
    .command_i    (command_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .byte_access_i(byte_access_i),
    .dec_o        (dec)
  );

  ibrd_ctrl_regs u_ctrl_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .dec_i       (dec),
    .raise_mask_i(raise_mask_i),
    .pending_o   (pending),
    .stat_o      (stat_d)
  );

  // flow control: stage one holds while the output register is full and not being taken
  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;
  assign accept     = in_valid_i && in_ready_o;
  assign mem_op     = accept && (dec.rd || dec.wr);

  // local stores
  ibrd_ram #(.WIDTH(16), .DEPTH(256)) u_clut (
    .clk_i(clk_i), .en_i(mem_op && dec.rgn == RGN_CLUT), .we_i(dec.wr),
    .addr_i(dec.clut_idx), .wdata_i(dec.wdata), .rdata_o(clut_rd)
  );

  ibrd_ram #(.WIDTH(16), .DEPTH(LINE_WORDS)) u_line_a (
    .clk_i(clk_i), .en_i(mem_op && dec.rgn == RGN_LINE_A), .we_i(dec.wr),
    .addr_i(dec.line_idx), .wdata_i(dec.wdata), .rdata_o(line_a_rd)
  );

  ibrd_ram #(.WIDTH(16), .DEPTH(LINE_WORDS)) u_line_b (
    .clk_i(clk_i), .en_i(mem_op && dec.rgn == RGN_LINE_B), .we_i(dec.wr),
    .addr_i(dec.line_idx), .wdata_i(dec.wdata), .rdata_o(line_b_rd)
  );

  ibrd_ram #(.WIDTH(16), .DEPTH(LINE_WORDS)) u_line_w (
    .clk_i(clk_i), .en_i(mem_op && dec.rgn == RGN_LINE_W), .we_i(dec.wr),
    .addr_i(dec.line_idx), .wdata_i(dec.wdata), .rdata_o(line_w_rd)
  );

  // high half sits at the lower address
  ibrd_ram #(.WIDTH(16), .DEPTH(GPU_WORDS)) u_gpu_hi (
    .clk_i(clk_i),
    .en_i(mem_op && dec.rgn == RGN_GPU && (dec.rd || !dec.half_lo)),
    .we_i(dec.wr), .addr_i(dec.gpu_idx), .wdata_i(dec.wdata), .rdata_o(gpu_hi_rd)
  );

  ibrd_ram #(.WIDTH(16), .DEPTH(GPU_WORDS)) u_gpu_lo (
    .clk_i(clk_i),
    .en_i(mem_op && dec.rgn == RGN_GPU && (dec.rd || dec.half_lo)),
    .we_i(dec.wr), .addr_i(dec.gpu_idx), .wdata_i(dec.wdata), .rdata_o(gpu_lo_rd)
  );

  ibrd_ram #(.WIDTH(16), .DEPTH(DSP_WORDS)) u_dsp_hi (
    .clk_i(clk_i),
    .en_i(mem_op && dec.rgn == RGN_DSP && (dec.rd || !dec.half_lo)),
    .we_i(dec.wr), .addr_i(dec.dsp_idx), .wdata_i(dec.wdata), .rdata_o(dsp_hi_rd)
  );

  ibrd_ram #(.WIDTH(16), .DEPTH(DSP_WORDS)) u_dsp_lo (
    .clk_i(clk_i),
    .en_i(mem_op && dec.rgn == RGN_DSP && (dec.rd || dec.half_lo)),
    .we_i(dec.wr), .addr_i(dec.dsp_idx), .wdata_i(dec.wdata), .rdata_o(dsp_lo_rd)
  );

  // stage one: access context while the ram read is in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_rgn_q     <= dec.rgn;
      s1_rd_q      <= dec.rd;
      s1_handled_q <= dec.handled;
      s1_byte_q    <= dec.byte_acc;
      s1_lane_q    <= dec.lane_odd;
      s1_half_q    <= dec.half_lo;
      s1_pend_q    <= pending;
      s1_stat_q    <= stat_d;
    end
  end

  // pick the half-word that was read
  always_comb begin
    case (s1_rgn_q)
      RGN_REG:    word_val = {11'd0, s1_pend_q};
      RGN_CLUT:   word_val = clut_rd;
      RGN_LINE_A: word_val = line_a_rd;
      RGN_LINE_B: word_val = line_b_rd;
      RGN_LINE_W: word_val = line_w_rd;
      RGN_GPU:    word_val = s1_half_q ? gpu_lo_rd : gpu_hi_rd;
      RGN_DSP:    word_val = s1_half_q ? dsp_lo_rd : dsp_hi_rd;
      default:    word_val = UNHANDLED_DATA;
    endcase
    if (!s1_handled_q) begin
      word_val = UNHANDLED_DATA;
    end
  end

  // byte lane select, zero for anything but a read
  always_comb begin
    if (!s1_rd_q) begin
      out_data_d = '0;
    end else if (s1_byte_q) begin
      out_data_d = {8'd0, s1_lane_q ? word_val[7:0] : word_val[15:8]};
    end else begin
      out_data_d = word_val;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q    <= out_data_d;
      out_handled_q <= s1_handled_q;
      out_stat_q    <= s1_stat_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign read_data_o       = out_data_q;
  assign handled_o         = out_handled_q;
  assign irq_o             = out_stat_q.irq;
  assign rom_high_o        = out_stat_q.rom_high;
  assign rom_wait_cycles_o = out_stat_q.wait_cycles;

`ifndef SYNTHESIS
  // an unhandled access returns zero, all ones, or the byte of all ones
  a_unhandled_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !handled_o |->
      read_data_o == 16'h0000 || read_data_o == 16'hFFFF || read_data_o == 16'h00FF)
    else $error("unhandled access returned unexpected data");

  // wait cycles are zero before the first memory control write, else from the table
  a_wait_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      rom_wait_cycles_o == 4'd0 || rom_wait_cycles_o == 4'd5 ||
      rom_wait_cycles_o == 4'd6 || rom_wait_cycles_o == 4'd8 ||
      rom_wait_cycles_o == 4'd10)
    else $error("illegal rom wait cycle count");

  // a transfer in always occupies stage one on the next cycle
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted access lost before stage one");

  // a stalled stage one blocks new transfers
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input taken while stage one is stalled");
`endif

endmodule

FILE: sim/internal_bus_register_decoder_unit_tb.sv
module internal_bus_register_decoder_unit_tb
  import ibrd_pkg::*;
();

  // command code the block does not define
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  // cartridge wait cycles by memory control bits 4:3
  localparam logic [3:0] ROM_WAITS [4] = '{4'd10, 4'd8, 4'd6, 4'd5};
  localparam logic [9:0] HALF_MASK = 10'h3FE;
  localparam int ACCESS_COUNT = 1800;

  typedef struct packed {
    logic [15:0] read_data;
    logic        handled;
    logic        irq;
    logic        rom_high;
    logic [3:0]  wait_cycles;
  } bus_result_t;

  // decoder state mirror and queue of expected results
  class decoder_scoreboard;
    logic [15:0] clut_mem [256];
    logic [15:0] line_mem [3*LINE_WORDS];
    logic [31:0] gpu_mem [GPU_WORDS];
    logic [31:0] dsp_mem [DSP_WORDS];
    bit          clut_set [256];
    bit          line_set [3*LINE_WORDS];
    bit [1:0]    gpu_set [GPU_WORDS];
    bit [1:0]    dsp_set [DSP_WORDS];
    logic [4:0]  int_enable = '0;
    logic [4:0]  irq_pending = '0;
    logic [15:0] memcon1 = '0;
    logic [15:0] memcon2 = '0;
    bit          memcon_seen = 1'b0;
    logic [3:0]  rom_wait = '0;
    bus_result_t expected_results [$];
    logic [23:0] stored_addrs [$];
    int          errors = 0;

    // region and entry index of an address; line stores share one index space
    function region_e decode(input logic [23:0] addr, output int idx);
      idx = 0;
      if (addr < SPACE_START || addr >= SPACE_END) return RGN_NONE;
      if (addr < REG_END) return RGN_REG;
      if (addr < CLUT_END) begin
        idx = int'(addr[8:1]);
        return RGN_CLUT;
      end
      if (addr < LINE_END) begin
        idx = int'(addr[10:1]);
        if (idx >= LINE_WORDS) return RGN_NONE;
        if (addr < LINE_B_START) return RGN_LINE_A;
        idx += LINE_WORDS;
        if (addr < LINE_W_START) return RGN_LINE_B;
        idx += LINE_WORDS;
        return RGN_LINE_W;
      end
      if (addr >= GPU_START && addr < GPU_END) begin
        idx = int'(addr >> 2) & (GPU_WORDS - 1);
        return RGN_GPU;
      end
      if (addr >= DSP_START && addr < DSP_END) begin
        idx = int'(addr >> 2) & (DSP_WORDS - 1);
        return RGN_DSP;
      end
      return RGN_NONE;
    endfunction

    // a read here only touches entries that hold written data
    function bit readable(input logic [23:0] addr);
      int idx;
      region_e rgn;
      rgn = decode(addr, idx);
      case (rgn)
        RGN_CLUT: return clut_set[idx];
        RGN_LINE_A, RGN_LINE_B, RGN_LINE_W: return line_set[idx];
        RGN_GPU: return gpu_set[idx][~addr[1]];
        RGN_DSP: return dsp_set[idx][~addr[1]];
        default: return 1'b1;
      endcase
    endfunction

    // half-word seen by a read, high half of a ram word at the lower address
    function logic [15:0] read_half(input logic [23:0] addr, output logic ok);
      int idx;
      region_e rgn;
      logic [31:0] word;
      rgn = decode(addr, idx);
      ok = 1'b1;
      case (rgn)
        RGN_REG: if ((addr[9:0] & HALF_MASK) == OFS_INT_CTRL) return {11'd0, irq_pending};
        RGN_CLUT: return clut_mem[idx];
        RGN_LINE_A, RGN_LINE_B, RGN_LINE_W: return line_mem[idx];
        RGN_GPU, RGN_DSP: begin
          word = (rgn == RGN_GPU) ? gpu_mem[idx] : dsp_mem[idx];
          return addr[1] ? word[15:0] : word[31:16];
        end
        default: ;
      endcase
      ok = 1'b0;
      return UNHANDLED_DATA;
    endfunction

    // half-word write, returns the handled flag
    function logic write_half(input logic [23:0] addr, input logic [15:0] val);
      int idx;
      region_e rgn;
      rgn = decode(addr, idx);
      case (rgn)
        RGN_REG: begin
          case (addr[9:0] & HALF_MASK)
            OFS_MEMCON1: begin
              // wait cycles reload on a rom_high change or the first write
              if (val[0] != memcon1[0] || !memcon_seen) begin
                memcon_seen = 1'b1;
                rom_wait = ROM_WAITS[val[4:3]];
              end
              memcon1 = val;
            end
            OFS_MEMCON2: memcon2 = val;
            OFS_INT_CTRL: begin
              int_enable = val[4:0];
              irq_pending &= ~val[12:8];
            end
            OFS_INT_AUX: ;
            default: return 1'b0;
          endcase
          return 1'b1;
        end
        RGN_CLUT: begin
          clut_mem[idx] = val;
          clut_set[idx] = 1'b1;
        end
        RGN_LINE_A, RGN_LINE_B, RGN_LINE_W: begin
          line_mem[idx] = val;
          line_set[idx] = 1'b1;
        end
        RGN_GPU: begin
          if (addr[1]) gpu_mem[idx][15:0] = val;
          else gpu_mem[idx][31:16] = val;
          gpu_set[idx][~addr[1]] = 1'b1;
        end
        RGN_DSP: begin
          if (addr[1]) dsp_mem[idx][15:0] = val;
          else dsp_mem[idx][31:16] = val;
          dsp_set[idx][~addr[1]] = 1'b1;
        end
        default: return 1'b0;
      endcase
      stored_addrs.push_back({addr[23:1], 1'b0});
      return 1'b1;
    endfunction

    // accepted access: update the mirror and queue its result
    function void note_access(input logic [1:0] cmd, input logic [23:0] addr,
                              input logic [15:0] data, input bit is_byte,
                              input logic [4:0] mask);
      bus_result_t res;
      logic [15:0] v;
      logic ok;
      res = '0;
      case (cmd)
        CMD_READ: begin
          v = read_half(addr, ok);
          if (!is_byte) res.read_data = v;
          else res.read_data = addr[0] ? {8'd0, v[7:0]} : {8'd0, v[15:8]};
          res.handled = ok;
        end
        CMD_WRITE: begin
          v = is_byte ? {data[7:0], data[7:0]} : data;
          res.handled = write_half(addr, v);
        end
        CMD_RAISE: begin
          irq_pending |= mask;
          res.handled = 1'b1;
        end
        default: ;
      endcase
      res.irq = |(int_enable & irq_pending);
      res.rom_high = memcon1[0];
      res.wait_cycles = rom_wait;
      expected_results.push_back(res);
    endfunction

    function void compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // result transfer against the oldest expectation
    function void check_result(input bus_result_t got);
      bus_result_t want;
      if (expected_results.size() == 0) begin
        $error("result with no access outstanding: read_data 0x%0h", got.read_data);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("handled", 16'(want.handled), 16'(got.handled));
      compare_field("irq", 16'(want.irq), 16'(got.irq));
      compare_field("rom_high", 16'(want.rom_high), 16'(got.rom_high));
      compare_field("rom_wait_cycles", 16'(want.wait_cycles), 16'(got.wait_cycles));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i = '0;
  logic [23:0] address_i = '0;
  logic [15:0] write_data_i = '0;
  logic        byte_access_i = 1'b0;
  logic [4:0]  raise_mask_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] read_data_o;
  logic        handled_o;
  logic        irq_o;
  logic        rom_high_o;
  logic [3:0]  rom_wait_cycles_o;

  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;
  decoder_scoreboard sb = new();

  internal_bus_register_decoder_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .address_i        (address_i),
    .write_data_i     (write_data_i),
    .byte_access_i    (byte_access_i),
    .raise_mask_i     (raise_mask_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .read_data_o      (read_data_o),
    .handled_o        (handled_o),
    .irq_o            (irq_o),
    .rom_high_o       (rom_high_o),
    .rom_wait_cycles_o(rom_wait_cycles_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // one access transfer after a random gap
  task automatic send_item(input logic [1:0] cmd, input logic [23:0] addr,
                           input logic [15:0] data, input bit is_byte,
                           input logic [4:0] mask);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    address_i     <= addr;
    write_data_i  <= data;
    byte_access_i <= is_byte;
    raise_mask_i  <= mask;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_access(cmd, addr, data, is_byte, mask);
  endtask

  // address spread over every region of the map and beyond it
  function automatic logic [23:0] random_address();
    logic [23:0] a;
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      case ($urandom_range(0, 4))
        0: a = SPACE_START + OFS_MEMCON1;
        1: a = SPACE_START + OFS_MEMCON2;
        2: a = SPACE_START + OFS_INT_CTRL;
        3: a = SPACE_START + OFS_INT_AUX;
        default: a = SPACE_START + 24'($urandom_range(0, 'h3FF));
      endcase
      a[0] = 1'($urandom_range(0, 1));
    end else if (r < 30) a = 24'($urandom_range(REG_END, CLUT_END - 1));
    else if (r < 50) a = 24'($urandom_range(CLUT_END, LINE_END - 1));
    else if (r < 70) a = 24'($urandom_range(GPU_START, GPU_END - 1));
    else if (r < 85) a = 24'($urandom_range(DSP_START, DSP_END - 1));
    else if (r < 93) begin
      case ($urandom_range(0, 2))
        0: a = 24'($urandom_range(LINE_END, GPU_START - 1));
        1: a = 24'($urandom_range(GPU_END, DSP_START - 1));
        default: a = 24'($urandom_range(DSP_END, SPACE_END - 1));
      endcase
    end else if ($urandom_range(0, 1)) a = 24'($urandom_range(0, SPACE_START - 1));
    else a = 24'($urandom_range(SPACE_END, 24'hFFFFFF));
    return a;
  endfunction

  // random access; reads of unwritten entries are steered to written ones
  task automatic send_random_access();
    logic [1:0] cmd;
    logic [23:0] a;
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) cmd = CMD_RAISE;
    else if (r < 10) cmd = CMD_UNKNOWN;
    else if (r < 55) cmd = CMD_READ;
    else cmd = CMD_WRITE;
    a = random_address();
    if (cmd == CMD_READ && !sb.readable(a)) begin
      if (sb.stored_addrs.size() > 0) begin
        a = sb.stored_addrs[$urandom_range(0, sb.stored_addrs.size() - 1)];
        a[0] = 1'($urandom_range(0, 1));
      end else cmd = CMD_WRITE;
    end
    send_item(cmd, a, 16'($urandom_range(0, 16'hFFFF)), $urandom_range(0, 9) < 3,
              5'($urandom_range(0, 31)));
  endtask

  // register corners, store ends, aliases and unmapped space
  task automatic run_directed();
    send_item(CMD_READ,    24'h100000, 16'h0000, 1'b0, 5'h00);
    send_item(CMD_WRITE,   24'h100000, 16'h0018, 1'b0, 5'h00);
    send_item(CMD_WRITE,   24'h100000, 16'h0008, 1'b0, 5'h00);
    send_item(CMD_WRITE,   24'h100001, 16'hFF01, 1'b1, 5'h00);
    send_item(CMD_WRITE,   24'h100002, 16'hFFFF, 1'b0, 5'h00);
    send_item(CMD_WRITE,   24'h1000E0, 16'h001F, 1'b0, 5'h00);
    send_item(CMD_RAISE,   24'hFFFFFF, 16'hFFFF, 1'b1, 5'h1F);
    send_item(CMD_READ,    24'h1000E1, 16'h0000, 1'b1, 5'h00);
    send_item(CMD_WRITE,   24'h1000E0, 16'h1F00, 1'b0, 5'h00);
    send_item(CMD_WRITE,   24'h1000E2, 16'h5555, 1'b0, 5'h00);
    send_item(CMD_WRITE,   24'h1003FE, 16'hAAAA, 1'b0, 5'h00);
    send_item(CMD_WRITE,   24'h100400, 16'hFFFF, 1'b0, 5'h00);
    send_item(CMD_WRITE,   24'h1007FF, 16'h00A5, 1'b1, 5'h00);
    send_item(CMD_READ,    24'h1007FE, 16'h0000, 1'b1, 5'h00);
    send_item(CMD_READ,    24'h100600, 16'h0000, 1'b0, 5'h00);
    send_item(CMD_WRITE,   24'h100D9E, 16'hC3A5, 1'b0, 5'h00);
    send_item(CMD_READ,    24'h100DA0, 16'h0000, 1'b0, 5'h00);
    send_item(CMD_READ,    24'h100D9F, 16'h0000, 1'b1, 5'h00);
    send_item(CMD_WRITE,   24'h1020FE, 16'h0000, 1'b0, 5'h00);
    send_item(CMD_WRITE,   24'h103000, 16'h1234, 1'b0, 5'h00);
    send_item(CMD_READ,    24'h104000, 16'h0000, 1'b0, 5'h00);
    send_item(CMD_WRITE,   24'h11CFFF, 16'h005A, 1'b1, 5'h00);
    send_item(CMD_READ,    24'h11CFFE, 16'h0000, 1'b1, 5'h00);
    send_item(CMD_READ,    24'h0FFFFF, 16'h0000, 1'b0, 5'h00);
    send_item(CMD_WRITE,   24'h120000, 16'h1234, 1'b0, 5'h00);
    send_item(CMD_UNKNOWN, 24'h100400, 16'h0F0F, 1'b0, 5'h1F);
  endtask

  // result side: random stall, then take and check one transfer
  task automatic collect_results();
    int stall;
    int count;
    count = 0;
    forever begin
      if (count % 200 == 0) recv_calm = ($urandom_range(0, 3) == 0);
      stall = recv_calm ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(bus_result_t'({read_data_o, handled_o, irq_o, rom_high_o,
                                     rom_wait_cycles_o}));
      count++;
    end
  endtask

  initial begin
    @(posedge rst_ni);
    collect_results();
  end

  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int n = 0; n < ACCESS_COUNT; n++) begin
      if (n % 200 == 0) send_calm = ($urandom_range(0, 3) == 0);
      send_random_access();
    end
    in_valid_i <= 1'b0;
    // drain, then allow for the pipeline
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
